@@ rtl/srr_pkg.sv @@
// Shared types and constants for the simplex rank/unrank block.
// Depends on nothing; every file of the block but srr_ram imports it.
`default_nettype none

package srr_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_POINTS_DEF   = 256;
	localparam int MAX_VERTICES_DEF = 8;
	localparam int INDEX_WIDTH_DEF  = 50;

	// Fixed field widths of the channels.
	localparam int VERTEX_W = 8;
	localparam int CODE_W   = 50;
	localparam int DIM_W    = 3;
	localparam int PC_W     = 9;

	// Vertex count carried in a queued command (covers up to eight vertices).
	localparam int CNT_W = 4;

	// Width of one binomial entry: C(256,8) needs 49 bits.
	localparam int BINOM_W = 49;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PC_W-1:0] PC_RESET = 9'd256;

	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [VERTEX_W-1:0] vertex;
		logic                vertex_last;
		logic [CODE_W-1:0]   code_index;
		logic [DIM_W-1:0]    dimension;
	} req_t;

	typedef struct packed {
		logic                result_kind;
		logic [CODE_W-1:0]   index_out;
		logic [VERTEX_W-1:0] vertex_out;
		logic                result_last;
		logic                overflow;
	} res_t;

	// Classified command as it travels through the queue.
	typedef struct packed {
		logic                is_decode;
		logic [VERTEX_W-1:0] vertex;
		logic                last;
		logic [CODE_W-1:0]   code;
		logic [CNT_W-1:0]    count;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/srr_if.sv @@
// Channel interfaces of the simplex rank/unrank block: request, result, config.
// Depends on srr_pkg for the payload types and widths.
`default_nettype none

interface srr_req_if;
	import srr_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srr_res_if;
	import srr_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface srr_cfg_if;
	import srr_pkg::*;
	logic            valid;
	logic            ready;
	logic [PC_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/srr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module srr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/srr_table.sv @@
// Binomial table: builds Pascal's triangle row by row into a RAM after reset.
// Depends on srr_pkg and srr_ram.
`default_nettype none

module srr_table #(
	parameter int MAX_POINTS   = srr_pkg::MAX_POINTS_DEF,
	parameter int MAX_VERTICES = srr_pkg::MAX_VERTICES_DEF,
	localparam int ADR_W = $clog2(MAX_POINTS + 1),
	localparam int ROW_W = (MAX_VERTICES + 1) * srr_pkg::BINOM_W
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             done,
	input  logic             rd_en,
	input  logic [ADR_W-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_row
);
	import srr_pkg::*;

	typedef logic [MAX_VERTICES:0][BINOM_W-1:0] row_t;

	logic [ADR_W-1:0] n_q;
	logic             done_q;
	row_t             prev_q;
	row_t             nxt;

	// Row n from row n-1; row 0 is one followed by zeros.
	always_comb begin
		nxt[0] = BINOM_W'(1);
		for (int k = 1; k <= MAX_VERTICES; k++) begin
			nxt[k] = (n_q == '0) ? '0 : prev_q[k-1] + prev_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			if (n_q == ADR_W'(MAX_POINTS)) begin
				done_q <= 1'b1;
			end else begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!done_q) begin
			prev_q <= nxt;
		end
	end

	srr_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_POINTS + 1)
	) u_ram (
		.clk     (clk),
		.wr_en   (!done_q),
		.wr_addr (n_q),
		.wr_data (nxt),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_row)
	);

	assign done = done_q;

endmodule

`default_nettype wire

@@ rtl/srr_front.sv @@
// Front end: accepts request beats and classifies them into queued commands.
// Depends on srr_pkg and srr_if.
`default_nettype none

module srr_front #(
	parameter int MAX_VERTICES = srr_pkg::MAX_VERTICES_DEF
) (
	srr_req_if.sink        req,
	input  logic           tbl_done,
	input  logic           q_full,
	output logic           push,
	output srr_pkg::cmd_t  cmd
);
	import srr_pkg::*;

	logic [CNT_W-1:0] dim_plus;

	// Nothing is taken until the binomial table is built.
	assign req.ready = tbl_done && !q_full;
	assign push      = req.valid && req.ready;
	assign dim_plus  = CNT_W'(req.data.dimension) + CNT_W'(1);

	always_comb begin
		cmd.is_decode = req.data.req_type;
		if (req.data.req_type == KIND_DECODE) begin
			cmd.vertex = '0;
			cmd.last   = 1'b0;
			cmd.code   = req.data.code_index;
			cmd.count  = (int'(dim_plus) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : dim_plus;
		end else begin
			cmd.vertex = req.data.vertex;
			cmd.last   = req.data.vertex_last;
			cmd.code   = '0;
			cmd.count  = '0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/srr_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on srr_pkg.
`default_nettype none

module srr_queue #(
	parameter int DEPTH = srr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  srr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output srr_pkg::cmd_t head
);
	import srr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/srr_back.sv @@
// Back end: runs encode accumulation and the greedy decode search on the table.
// Depends on srr_pkg and srr_if; reads rows from srr_table.
`default_nettype none

module srr_back #(
	parameter int MAX_POINTS   = srr_pkg::MAX_POINTS_DEF,
	parameter int MAX_VERTICES = srr_pkg::MAX_VERTICES_DEF,
	parameter int INDEX_WIDTH  = srr_pkg::INDEX_WIDTH_DEF,
	localparam int ADR_W = $clog2(MAX_POINTS + 1),
	localparam int ROW_W = (MAX_VERTICES + 1) * srr_pkg::BINOM_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [srr_pkg::PC_W-1:0] point_count,
	input  logic                     cmd_valid,
	input  srr_pkg::cmd_t            cmd,
	output logic                     cmd_pop,
	output logic                     tbl_rd_en,
	output logic [ADR_W-1:0]         tbl_rd_addr,
	input  logic [ROW_W-1:0]         tbl_rd_row,
	srr_res_if.source                res
);
	import srr_pkg::*;

	localparam int KW    = $clog2(MAX_VERTICES + 1);
	localparam int DV_IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW    = (INDEX_WIDTH > BINOM_W) ? INDEX_WIDTH : BINOM_W;

	typedef logic [MAX_VERTICES:0][BINOM_W-1:0] row_t;

	typedef enum logic [4:0] {
		ST_IDLE       = 5'b00001,
		ST_ENC_ADD    = 5'b00010,
		ST_DEC_START  = 5'b00100,
		ST_DEC_SEARCH = 5'b01000,
		ST_EMIT       = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [INDEX_WIDTH-1:0] acc_q, acc_d;
	logic [KW-1:0]        pos_q, pos_d;
	logic                 ovf_q, ovf_d;
	logic [VERTEX_W-1:0]  vtx_q, vtx_d;
	logic                 last_q, last_d;
	logic [INDEX_WIDTH-1:0] rem_q, rem_d;
	logic [BINOM_W-1:0]   sub_q, sub_d;
	logic [BINOM_W-1:0]   cur_b_q, cur_b_d;
	logic [VERTEX_W-1:0]  v_q, v_d;
	logic [KW-1:0]        step_q, step_d;
	logic [KW-1:0]        cnt_q, cnt_d;
	logic [DV_IW-1:0]     emit_q, emit_d;
	logic [VERTEX_W-1:0]  dv_q [MAX_VERTICES];
	logic                 out_valid_q;
	res_t                 out_q, out_d;
	logic                 out_we;

	row_t                 row;
	logic                 slot_free;
	logic                 enc_room;
	logic                 enc_hit;
	logic [KW-1:0]        enc_k;
	logic [BINOM_W-1:0]   enc_b;
	logic [INDEX_WIDTH-1:0] enc_acc;
	logic [KW-1:0]        enc_pos;
	logic                 enc_ovf;
	logic [BINOM_W-1:0]   srch_b;
	logic                 srch_ok;
	logic [VERTEX_W-1:0]  v_inc;
	logic                 emit_last;
	logic                 fin;
	logic [VERTEX_W-1:0]  fin_v;
	logic [BINOM_W-1:0]   fin_b;
	logic                 dv_we;
	logic [DV_IW-1:0]     dv_idx;

	// True when the search may try vertex v+1.
	function automatic logic can_step(logic [VERTEX_W-1:0] v, logic [PC_W-1:0] pc);
		int nxt;
		nxt = int'(v) + 1;
		return (nxt < int'(pc)) && (nxt < MAX_POINTS);
	endfunction

	assign row       = tbl_rd_row;
	assign slot_free = !out_valid_q || res.ready;

	// Encode: C(vertex, position+1), zero beyond the point count.
	assign enc_room = int'(pos_q) < MAX_VERTICES;
	assign enc_hit  = ({1'b0, vtx_q} <= point_count) && (int'(vtx_q) <= MAX_POINTS);
	assign enc_k    = enc_room ? KW'(pos_q + 1'b1) : '0;
	assign enc_b    = (enc_room && enc_hit) ? row[enc_k] : '0;
	assign enc_acc  = INDEX_WIDTH'(CW'(acc_q) + CW'(enc_b));
	assign enc_pos  = enc_room ? KW'(pos_q + 1'b1) : pos_q;
	assign enc_ovf  = enc_room ? ovf_q : 1'b1;

	// Decode: the row for the candidate v+1 arrives while in the search state.
	assign srch_b    = row[step_q];
	assign srch_ok   = CW'(srch_b) <= CW'(rem_q);
	assign v_inc     = v_q + 1'b1;
	assign emit_last = (emit_q == DV_IW'(cnt_q - 1'b1));

	always_comb begin
		state_d     = state_q;
		acc_d       = acc_q;
		pos_d       = pos_q;
		ovf_d       = ovf_q;
		vtx_d       = vtx_q;
		last_d      = last_q;
		rem_d       = rem_q;
		sub_d       = sub_q;
		cur_b_d     = cur_b_q;
		v_d         = v_q;
		step_d      = step_q;
		cnt_d       = cnt_q;
		emit_d      = emit_q;
		out_d       = out_q;
		out_we      = 1'b0;
		cmd_pop     = 1'b0;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = '0;
		fin         = 1'b0;
		fin_v       = v_q;
		fin_b       = cur_b_q;
		dv_we       = 1'b0;
		dv_idx      = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.is_decode) begin
						rem_d   = INDEX_WIDTH'(cmd.code);
						cnt_d   = KW'(cmd.count);
						step_d  = KW'(cmd.count);
						v_d     = VERTEX_W'(cmd.count - 1'b1);
						sub_d   = '0;
						state_d = ST_DEC_START;
					end else begin
						vtx_d       = cmd.vertex;
						last_d      = cmd.last;
						tbl_rd_en   = 1'b1;
						tbl_rd_addr = (int'(cmd.vertex) <= MAX_POINTS) ?
							ADR_W'(cmd.vertex) : '0;
						state_d     = ST_ENC_ADD;
					end
				end
			end
			ST_ENC_ADD: begin
				if (!last_q) begin
					acc_d   = enc_acc;
					pos_d   = enc_pos;
					ovf_d   = enc_ovf;
					state_d = ST_IDLE;
				end else if (slot_free) begin
					out_we            = 1'b1;
					out_d.result_kind = KIND_ENCODE;
					out_d.index_out   = CODE_W'(enc_acc);
					out_d.vertex_out  = '0;
					out_d.result_last = 1'b1;
					out_d.overflow    = enc_ovf;
					acc_d             = '0;
					pos_d             = '0;
					ovf_d             = 1'b0;
					state_d           = ST_IDLE;
				end
			end
			ST_DEC_START: begin
				// Take off the binomial chosen by the previous step.
				rem_d   = INDEX_WIDTH'(CW'(rem_q) - CW'(sub_q));
				cur_b_d = '0;
				if (can_step(v_q, point_count)) begin
					tbl_rd_en   = 1'b1;
					tbl_rd_addr = ADR_W'(v_inc);
					state_d     = ST_DEC_SEARCH;
				end else begin
					fin   = 1'b1;
					fin_v = v_q;
					fin_b = '0;
				end
			end
			ST_DEC_SEARCH: begin
				if (srch_ok) begin
					v_d     = v_inc;
					cur_b_d = srch_b;
					if (can_step(v_inc, point_count)) begin
						// Fetch the next candidate ahead of the compare.
						tbl_rd_en   = 1'b1;
						tbl_rd_addr = ADR_W'(v_inc + 1'b1);
					end else begin
						fin   = 1'b1;
						fin_v = v_inc;
						fin_b = srch_b;
					end
				end else begin
					fin   = 1'b1;
					fin_v = v_q;
					fin_b = cur_b_q;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_we            = 1'b1;
					out_d.result_kind = KIND_DECODE;
					out_d.index_out   = '0;
					out_d.vertex_out  = dv_q[emit_q];
					out_d.result_last = emit_last;
					out_d.overflow    = 1'b0;
					if (emit_last) begin
						state_d = ST_IDLE;
					end else begin
						emit_d = emit_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// End of one search step: store the vertex and move to the next one down.
		if (fin) begin
			dv_we  = 1'b1;
			dv_idx = DV_IW'(step_q - 1'b1);
			sub_d  = fin_b;
			if (step_q == KW'(1)) begin
				emit_d  = '0;
				state_d = ST_EMIT;
			end else begin
				step_d  = step_q - 1'b1;
				v_d     = VERTEX_W'(step_q - KW'(2));
				state_d = ST_DEC_START;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			step_q      <= '0;
			cnt_q       <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
			emit_q  <= emit_d;
			if (out_we) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vtx_q   <= vtx_d;
		last_q  <= last_d;
		rem_q   <= rem_d;
		sub_q   <= sub_d;
		cur_b_q <= cur_b_d;
		v_q     <= v_d;
		out_q   <= out_d;
		if (dv_we) begin
			dv_q[dv_idx] <= fin_v;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

endmodule

`default_nettype wire

@@ rtl/simplex_rank_unrank.sv @@
// Top level of the simplex rank/unrank block (combinatorial number system).
// Depends on srr_pkg, srr_if, srr_front, srr_queue, srr_table and srr_back.
`default_nettype none

// Channel  Role  Payload                                            Beat taken when
// cfg      sink  point_count, 9 bits                                cfg.valid && cfg.ready
// req      sink  req_type, vertex, vertex_last, code_index, dim     req.valid && req.ready
// res      src   result_kind, index_out, vertex_out, last, overflow res.valid && res.ready
//
// After reset the binomial table is built one row per cycle, rows 0 to MAX_POINTS;
// req.ready stays low for that time, configuration beats are taken throughout. An
// encode beat is a table read followed by an add in the back end. A decode beat
// leaves the queue, then for each vertex passes a start state and a search state that
// tries one table row after another (the vertex climbs from one below its step
// number, never up to the point count), then the vertices are delivered one per cycle
// while the result register is not stalled. A two-entry queue lets the front take
// beats while the back works or waits on a stalled result register.

module simplex_rank_unrank #(
	parameter int MAX_POINTS   = srr_pkg::MAX_POINTS_DEF,
	parameter int MAX_VERTICES = srr_pkg::MAX_VERTICES_DEF,
	parameter int INDEX_WIDTH  = srr_pkg::INDEX_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srr_cfg_if.sink   cfg,
	srr_req_if.sink   req,
	srr_res_if.source res
);
	import srr_pkg::*;

	localparam int ADR_W = $clog2(MAX_POINTS + 1);
	localparam int ROW_W = (MAX_VERTICES + 1) * BINOM_W;

	logic [PC_W-1:0]  pc_q;
	logic             push;
	cmd_t             push_cmd;
	logic             q_full;
	logic             q_valid;
	cmd_t             q_head;
	logic             q_pop;
	logic             tbl_done;
	logic             rd_en;
	logic [ADR_W-1:0] rd_addr;
	logic [ROW_W-1:0] rd_row;

	// The point count register accepts a write in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			pc_q <= cfg.data;
		end
	end

	// Front end: gates acceptance on the table being built and queue space.
	srr_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.req      (req),
		.tbl_done (tbl_done),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	srr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// Pascal's triangle, one row of MAX_VERTICES + 1 binomials per address.
	srr_table #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_VERTICES (MAX_VERTICES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.done    (tbl_done),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	// Back end: encode run state, decode search and the result register.
	srr_back #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_VERTICES (MAX_VERTICES),
		.INDEX_WIDTH  (INDEX_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (pc_q),
		.cmd_valid   (q_valid),
		.cmd         (q_head),
		.cmd_pop     (q_pop),
		.tbl_rd_en   (rd_en),
		.tbl_rd_addr (rd_addr),
		.tbl_rd_row  (rd_row),
		.res         (res)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_simplex_rank_unrank.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for simplex_rank_unrank: ranking and unranking in the
// combinatorial number system. Depends on srr_pkg, the srr_*_if interfaces and the RTL.

module tb_simplex_rank_unrank;
	import srr_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int NPTS           = MAX_POINTS_DEF;
	localparam int NVERT          = MAX_VERTICES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int REPORT_LIMIT   = 10;
	localparam longint unsigned CODE_MASK = (64'd1 << INDEX_WIDTH_DEF) - 64'd1;

	// Scoreboard: a private copy of the block's state and point count, which turns
	// every accepted request beat into the result beats it must cause, in order.
	class rank_scoreboard;
		longint unsigned pascal[0:NPTS][0:NVERT];
		int unsigned     points;
		longint unsigned rank_sum;
		int unsigned     position;
		bit              overflowed;
		res_t            expected_q[$];
		int unsigned     mismatches;

		function new();
			for (int n = 0; n <= NPTS; n++) begin
				pascal[n][0] = 64'd1;
				for (int k = 1; k <= NVERT; k++) begin
					if (k > n)
						pascal[n][k] = 64'd0;
					else if (k == n)
						pascal[n][k] = 64'd1;
					else
						pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
				end
			end
			points     = PC_RESET;
			rank_sum   = 64'd0;
			position   = 0;
			overflowed = 1'b0;
			mismatches = 0;
		endfunction

		// A binomial whose top lies above the point count is taken as zero.
		function longint unsigned binom(int unsigned n, int unsigned k);
			if (n > points || n > NPTS || k > NVERT || k > n)
				return 64'd0;
			return pascal[n][k];
		endfunction

		function void set_points(logic [PC_W-1:0] value);
			points = value;
		endfunction

		function void note_request(req_t r);
			res_t                e;
			int unsigned         count;
			int unsigned         v;
			longint unsigned     rest;
			logic [VERTEX_W-1:0] found[NVERT];
			if (r.req_type == KIND_ENCODE) begin
				// Past the last position the vertex adds nothing and flags overflow.
				if (position < NVERT) begin
					rank_sum = (rank_sum + binom(r.vertex, position + 1)) & CODE_MASK;
					position++;
				end else begin
					overflowed = 1'b1;
				end
				if (r.vertex_last) begin
					e.result_kind = KIND_ENCODE;
					e.index_out   = rank_sum[CODE_W-1:0];
					e.vertex_out  = '0;
					e.result_last = 1'b1;
					e.overflow    = overflowed;
					expected_q.insert(expected_q.size(), e);
					rank_sum   = 64'd0;
					position   = 0;
					overflowed = 1'b0;
				end
			end else begin
				count = r.dimension + 1;
				if (count > NVERT)
					count = NVERT;
				rest = r.code_index;
				// Greedy search from the highest step down; the search never climbs
				// to the point count, so an oversized index saturates the vertices.
				for (int i = count; i >= 1; i--) begin
					v = i - 1;
					while (v + 1 < points && v + 1 < NPTS && binom(v + 1, i) <= rest)
						v++;
					rest -= binom(v, i);
					found[i-1] = VERTEX_W'(v);
				end
				for (int j = 0; j < count; j++) begin
					e.result_kind = KIND_DECODE;
					e.index_out   = '0;
					e.vertex_out  = found[j];
					e.result_last = (j + 1 == count);
					e.overflow    = 1'b0;
					expected_q.insert(expected_q.size(), e);
				end
			end
		endfunction

		function string describe(res_t r);
			return $sformatf("kind=%0d index=%0d vertex=%0d last=%0d ovf=%0d",
				r.result_kind, r.index_out, r.vertex_out, r.result_last, r.overflow);
		endfunction

		function void report(string what, res_t want, res_t got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s: expected %s, got %s",
					$time, what, describe(want), describe(got));
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected", '0, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.result_kind !== want.result_kind || got.index_out !== want.index_out ||
			    got.vertex_out !== want.vertex_out || got.result_last !== want.result_last ||
			    got.overflow !== want.overflow)
				report("result mismatch", want, got);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	srr_cfg_if cfg();
	srr_req_if req();
	srr_res_if res();

	rank_scoreboard sb;

	// Percentages of cycles in which the request side holds back and the result
	// side refuses a beat; the main sequence changes them from phase to phase.
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int stall_cycles   = 0;

	simplex_rank_unrank i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The result side decides afresh at every falling edge whether to take a beat.
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// All handshakes are sampled at the rising edge. The point count is tracked as
	// the block takes it, requests are predicted as they are taken, and results are
	// checked as they leave. The watchdog counts cycles in which no beat moves on
	// any channel; the longest correct gap is one decode search over all steps.
	always @(posedge clk) begin
		if (cfg.valid && cfg.ready)
			sb.set_points(cfg.data);
		if (req.valid && req.ready)
			sb.note_request(req.data);
		if (res.valid && res.ready)
			sb.check_result(res.data);
		if ((cfg.valid && cfg.ready) || (req.valid && req.ready) || (res.valid && res.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic longint unsigned random_code();
		return {$urandom, $urandom} & CODE_MASK;
	endfunction

	// Fields that the chosen request type ignores still carry random bits.
	function automatic req_t encode_beat(int v, bit last);
		req_t r;
		r.req_type    = KIND_ENCODE;
		r.vertex      = VERTEX_W'(v);
		r.vertex_last = last;
		r.code_index  = random_code();
		r.dimension   = DIM_W'($urandom);
		return r;
	endfunction

	function automatic req_t decode_beat(longint unsigned code, int dim);
		req_t r;
		r.req_type    = KIND_DECODE;
		r.vertex      = VERTEX_W'($urandom);
		r.vertex_last = 1'(($urandom));
		r.code_index  = code[CODE_W-1:0];
		r.dimension   = DIM_W'(dim);
		return r;
	endfunction

	// Called and left at a falling edge. Valid stays high after the beat is taken,
	// so that a following beat or an idle cycle is the only change in that step.
	task automatic send_request(req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic write_points(int value);
		cfg.valid <= 1'b1;
		cfg.data  <= PC_W'(value);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Holds the request side until every predicted result has left the block, then
	// gives a trailing encode beat (which causes no result) time to clear the queue.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One ascending simplex of len vertices drawn from 0..top.
	task automatic send_simplex(int len, int top);
		bit taken[NPTS];
		int picked;
		int sent;
		int x;
		taken  = '{default: 1'b0};
		picked = 0;
		while (picked < len) begin
			x = $urandom_range(top, 0);
			if (!taken[x]) begin
				taken[x] = 1'b1;
				picked++;
			end
		end
		sent = 0;
		for (int v = 0; v < NPTS; v++) begin
			if (taken[v]) begin
				sent++;
				send_request(encode_beat(v, sent == len));
			end
		end
	endtask

	// Random traffic: mostly well-formed simplices and decodes within the range of
	// the current point count, with overlong runs, stray vertices and oversized
	// indices mixed in.
	task automatic random_traffic(int n_items);
		int made;
		int pick;
		int len;
		int top;
		int dim;
		longint unsigned lim;
		longint unsigned code;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = $urandom_range(NVERT, 1);
				top = (sb.points > len && $urandom_range(7) != 0) ? sb.points - 1 : NPTS - 1;
				send_simplex(len, top);
				made += len;
			end else if (pick < 55) begin
				len = $urandom_range(NVERT + 4, NVERT + 1);
				send_simplex(len, NPTS - 1);
				made += len;
			end else if (pick < 65) begin
				send_request(encode_beat($urandom_range(NPTS - 1), $urandom_range(1)));
				made++;
			end else begin
				dim  = $urandom_range(7);
				lim  = sb.binom(sb.points, dim + 1);
				code = (lim == 0 || $urandom_range(9) < 2) ? random_code()
					: ({$urandom, $urandom} % lim);
				send_request(decode_beat(code, dim));
				made++;
			end
		end
	endtask

	initial begin
		int phase_points[8];
		sb = new();
		phase_points = '{1, 255, 20, 9, 2, 100, 256, 0};
		arst_n     = 1'b0;
		cfg.valid  = 1'b0;
		cfg.data   = '0;
		req.valid  = 1'b0;
		req.data   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register is taken while the table is still being built.
		write_points(256);

		// Directed beats: lone lowest and highest vertices, a run that spills past
		// the last position, an unsorted run, and decodes of a zero index, of an
		// all-ones index at the smallest and largest dimension, and of the top
		// index that fits.
		send_request(encode_beat(0, 1'b1));
		send_request(encode_beat(NPTS - 1, 1'b1));
		for (int i = 0; i <= NVERT; i++)
			send_request(encode_beat(NPTS - 1 - NVERT + i, i == NVERT));
		send_request(encode_beat(5, 1'b0));
		send_request(encode_beat(3, 1'b0));
		send_request(encode_beat(200, 1'b1));
		send_request(decode_beat(64'd0, 0));
		send_request(decode_beat(CODE_MASK, 7));
		send_request(decode_beat(CODE_MASK, 0));
		send_request(decode_beat(sb.binom(NPTS, NVERT) - 1, 7));
		send_request(decode_beat(64'd123456789, 3));

		// Each phase takes a new point count while the block is drained, covering
		// the single point, the full range and points that are too few for the
		// higher steps, and cycles through the four flow-control patterns.
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_points(phase_points[p] == 0 ? $urandom_range(NPTS, 1) : phase_points[p]);
			case ((p + 1) % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 62;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 62;
				end
				default: begin
					src_idle_pct   = 36;
					sink_stall_pct = 36;
				end
			endcase
			random_traffic(12);
		end

		wait_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
